>>> sv/ups_pkg.sv
// Package for the unique pair set: field widths, defaults, mode codes
// and the command/status structs passed between controller and datapath.
// No dependencies.
package ups_pkg;

  localparam int KEY_FIELD_W     = 32;
  localparam int VALUE_FIELD_W   = 32;
  localparam int COUNT_W         = 7;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_VALUE_BITS  = 32;

  localparam logic MODE_INSERT   = 1'b0;
  localparam logic MODE_QUERY    = 1'b1;

  typedef struct packed {
    logic load;    // capture the accepted word, restart the scan
    logic scan;    // issue the next entry read, compare the previous one
    logic commit;  // append if needed, load the result register
  } ups_cmd_t;

  typedef struct packed {
    logic hit;       // entry read last cycle matches the pair
    logic scan_end;  // every filled entry has been compared
    logic out_free;  // result register can take a new word
  } ups_stat_t;

endpackage

>>> sv/ups_if.sv
// Channel interfaces for the unique pair set: item in, result out.
// Depends on ups_pkg for the field widths.
interface ups_in_if;
  import ups_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [KEY_FIELD_W-1:0]   pair_key;
  logic [VALUE_FIELD_W-1:0] pair_value;

  modport source (output valid, output mode, output pair_key, output pair_value,
                  input ready);
  modport sink   (input valid, input mode, input pair_key, input pair_value,
                  output ready);
endinterface

interface ups_out_if;
  import ups_pkg::*;

  logic               valid;
  logic               ready;
  logic               present;
  logic               added;
  logic               full_refused;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output present, output added, output full_refused,
                  output entry_count, input ready);
  modport sink   (input valid, input present, input added, input full_refused,
                  input entry_count, output ready);
endinterface

>>> sv/ups_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ups_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/ups_ctrl.sv
// Controller for the unique pair set: accept, scan, commit sequencing.
// Depends on ups_pkg for the command and status structs.
module ups_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ups_pkg::ups_stat_t stat,
  output ups_pkg::ups_cmd_t  cmd
);
  import ups_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.scan_end) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register drains
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/ups_dp.sv
// Datapath for the unique pair set: item registers, pair RAM, scan index,
// fill count and result register. Depends on ups_pkg and ups_ram.
module ups_dp #(
  parameter int CAPACITY   = ups_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = ups_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = ups_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ups_pkg::ups_cmd_t                 cmd,
  output ups_pkg::ups_stat_t                stat,
  input  logic                              in_mode,
  input  logic [ups_pkg::KEY_FIELD_W-1:0]   in_pair_key,
  input  logic [ups_pkg::VALUE_FIELD_W-1:0] in_pair_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_present,
  output logic                              out_added,
  output logic                              out_full_refused,
  output logic [ups_pkg::COUNT_W-1:0]       out_entry_count
);
  import ups_pkg::*;

  localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int VW = (VALUE_BITS < VALUE_FIELD_W) ? VALUE_BITS : VALUE_FIELD_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mode_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  logic          outv_r, outv_nxt;
  logic          present_r, added_r, refused_r;
  logic [COUNT_W-1:0] count_r;

  logic          rd_en;
  logic [KW+VW-1:0] rd_data;
  logic          match;
  logic          insert;
  logic          room;
  logic          wr_en;

  ups_ram #(
    .WIDTH (KW + VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fill_r[AW-1:0]),
    .wdata ({key_r, val_r}),
    .re    (rd_en),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign match  = pend_r && (rd_data == {key_r, val_r});
  assign rd_en  = cmd.scan && (idx_r != fill_r);
  assign insert = (mode_r == MODE_INSERT) && !found_r;
  assign room   = (fill_r != CW'(CAPACITY));
  assign wr_en  = cmd.commit && insert && room;

  assign stat.hit      = match;
  assign stat.scan_end = !pend_r && (idx_r == fill_r);
  assign stat.out_free = !outv_r || out_ready;

  always_comb begin
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    found_nxt = found_r;
    if (cmd.load) begin
      idx_nxt   = '0;
      pend_nxt  = 1'b0;
      found_nxt = 1'b0;
    end else if (cmd.scan) begin
      pend_nxt  = rd_en;
      found_nxt = found_r | match;
      if (rd_en) begin
        idx_nxt = idx_r + CW'(1);
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en) begin
      fill_nxt = fill_r + CW'(1);
    end
  end

  always_comb begin
    outv_nxt = outv_r;
    if (cmd.commit) begin
      outv_nxt = 1'b1;
    end else if (out_ready) begin
      outv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= '0;
      fill_r  <= '0;
      outv_r  <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
      fill_r  <= fill_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r  <= in_pair_key[KW-1:0];
      val_r  <= in_pair_value[VW-1:0];
    end
    if (cmd.commit) begin
      present_r <= found_r;
      added_r   <= insert && room;
      refused_r <= insert && !room;
      count_r   <= COUNT_W'(fill_nxt);
    end
  end

  assign out_valid        = outv_r;
  assign out_present      = present_r;
  assign out_added        = added_r;
  assign out_full_refused = refused_r;
  assign out_entry_count  = count_r;

endmodule

>>> sv/unique_pair_set.sv
// Unique pair set: bounded store of distinct key/value pairs searched in order.
// Depends on ups_pkg, ups_if, ups_ctrl and ups_dp.
//
// Input channel in_ch carries one word per item: mode (insert or query),
// pair_key and pair_value. Result channel out_ch returns exactly one word per
// item: present (pair was stored before), added (insert stored it), full_refused
// (insert of an absent pair found CAPACITY entries) and entry_count (fill after
// the item, low 7 bits).
// Each item scans the filled entries one per cycle through the RAM read port.
// From acceptance to its result word, the steps are: read and compare the
// filled entries (stopping early on a hit), commit, then hold the word in the
// result register.
// Items are handled one at a time; in_ch.ready is high only between items.
// The result sits in an output register, so the next item is accepted and
// scanned while the previous result waits; a stalled receiver holds the block
// only when the next result is ready to commit.
// Reset clears the fill count and the handshake state; stored pairs are not
// cleared, they are simply no longer counted as filled.
module unique_pair_set #(
  parameter int CAPACITY   = ups_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = ups_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = ups_pkg::DEF_VALUE_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  ups_in_if.sink         in_ch,
  ups_out_if.source      out_ch
);
  import ups_pkg::*;

  ups_cmd_t  cmd;
  ups_stat_t stat;

  ups_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ups_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_ch.mode),
    .in_pair_key      (in_ch.pair_key),
    .in_pair_value    (in_ch.pair_value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_present      (out_ch.present),
    .out_added        (out_ch.added),
    .out_full_refused (out_ch.full_refused),
    .out_entry_count  (out_ch.entry_count)
  );

endmodule

>>> sv/ups_checker.sv
// Port-level checks for the unique pair set, bound to the top level.
// Depends on ups_pkg for the count width.
module ups_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_present,
  input logic                        out_added,
  input logic                        out_full_refused,
  input logic [ups_pkg::COUNT_W-1:0] out_entry_count
);
  import ups_pkg::*;

  logic [COUNT_W-1:0] last_count_r;

  // track the count of the last delivered word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
    end else if (out_valid && out_ready) begin
      last_count_r <= out_entry_count;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_present, out_added, out_full_refused}) <= 1)
    else $error("conflicting result flags");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count == COUNT_W'(last_count_r + COUNT_W'(out_added)))
    else $error("entry count does not follow added");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared before any scan");

endmodule

bind unique_pair_set ups_checker u_ups_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_present      (out_ch.present),
  .out_added        (out_ch.added),
  .out_full_refused (out_ch.full_refused),
  .out_entry_count  (out_ch.entry_count)
);
